// ===== sv/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// shared types and codes for the matrix multiplier core
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam logic [1:0] MODE_LOAD_A   = 2'd0;
  localparam logic [1:0] MODE_LOAD_B   = 2'd1;
  localparam logic [1:0] MODE_COMPUTE  = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_COLS_B    = 2'd1;
  localparam logic [1:0] CFG_INNER_LEN = 2'd2;
  localparam logic [1:0] CFG_RESERVED  = 2'd3;

  localparam int FRAC_BITS = 8;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element_value;
  } mm_in_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [15:0] out_value;
    logic               saturated;
    logic               last;
  } mm_out_t;

  // operand handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [2:0]         inner;
    logic signed [15:0] value;
  } mm_opnd_t;

  // broadcast control to all cells
  typedef struct packed {
    logic               clear;
    logic               shift;
    logic               b_we;
    logic [2:0]         b_row;
    logic [2:0]         b_col;
    logic signed [15:0] b_data;
  } mm_cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_EMIT
  } mm_state_e;

endpackage

// ===== sv/mm_cell.sv =====
// ----------------------------------------------------------------------------
// mm_cell
// one result column: holds a column of B, accumulates a dot product and
// passes operands and accumulators along the chain
// ----------------------------------------------------------------------------
module mm_cell #(
  parameter int MAX_DIM  = 8,
  parameter int CELL_IDX = 0,
  parameter int ACC_W    = 36
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mm_pkg::mm_cell_ctl_t    ctl_i,
  input  mm_pkg::mm_opnd_t        opnd_i,
  output mm_pkg::mm_opnd_t        opnd_o,
  input  logic signed [ACC_W-1:0] shift_in_i,
  output logic signed [ACC_W-1:0] acc_o
);
  import mm_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [15:0]      bcol_q [MAX_DIM];
  logic signed [15:0]      b_sel;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc_q;
  mm_opnd_t                fwd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.b_we && (int'(ctl_i.b_col) == CELL_IDX)) begin
      bcol_q[ctl_i.b_row[IDX_W-1:0]] <= ctl_i.b_data;
    end
  end

  assign b_sel = bcol_q[opnd_i.inner[IDX_W-1:0]];
  assign prod  = opnd_i.value * b_sel;

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (ctl_i.shift) begin
      acc_q <= shift_in_i;
    end else if (opnd_i.valid) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
    end else begin
      fwd_q <= opnd_i;
    end
  end

  assign opnd_o = fwd_q;
  assign acc_o  = acc_q;

endmodule

// ===== sv/matrix_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// matrix_multiplier_core
// C = A x B on signed Q8.8 elements, one result per element of C
// ----------------------------------------------------------------------------
// channel   ports                               handshake
// command   start_i, busy_o, in_i               start_i & !busy_o
// result    result_valid_o, result_o            one-cycle strobe
// config    cfg_valid_i, cfg_ready_o, cfg_*     valid & ready
//
// a load item does not raise busy_o; a compute item keeps busy_o high while,
// per row of C, ST_FEED streams A through the cell chain, ST_WAIT lets it
// drain and ST_EMIT shifts results out.
// each result leaves the output register in the cycle after its emit state.
// reset clears control only; stores hold garbage until written.
// the receiver cannot stall results.
// ----------------------------------------------------------------------------
module matrix_multiplier_core #(
  parameter int MAX_DIM     = 8,
  parameter int VALUE_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  mm_pkg::mm_in_t   in_i,
  output logic             result_valid_o,
  output mm_pkg::mm_out_t  result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [3:0]       cfg_data_i
);
  import mm_pkg::*;

  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int ACC_W    = 32 + $clog2(MAX_DIM) + 1;
  localparam int OUT_BITS = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic [3:0] rows_a_q, cols_b_q, inner_len_q;

  mm_state_e       state_q, state_d;
  logic [DIM_W-1:0] m_q, m_d, n_q, n_d, k_q, k_d;
  logic [DIM_W-1:0] i_q, i_d, l_q, l_d, w_q, w_d, e_q, e_d;

  logic signed [15:0] mem_a [MAX_DIM * MAX_DIM];
  logic signed [15:0] rd_data_q;
  logic [2:0]         rd_inner_q;
  logic               rd_vld_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               accept, in_range, a_we, feed, emit;

  mm_cell_ctl_t            ctl;
  mm_opnd_t                opnd [MAX_DIM + 1];
  logic signed [ACC_W-1:0] acc_w [MAX_DIM + 1];
  logic signed [ACC_W-1:0] shifted;

  mm_out_t res_q;
  logic    res_vld_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] v);
    logic [DIM_W-1:0] r;
    if (v == 4'd0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= 4'd8;
      cols_b_q    <= 4'd8;
      inner_len_q <= 4'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        CFG_INNER_LEN: inner_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = (int'(in_i.row_index) < MAX_DIM) && (int'(in_i.col_index) < MAX_DIM);
  assign a_we     = accept && in_range && (in_i.mode == MODE_LOAD_A);
  assign wr_addr  = ADDR_W'(int'(in_i.row_index) * MAX_DIM + int'(in_i.col_index));
  assign rd_addr  = ADDR_W'(int'(i_q) * MAX_DIM + int'(l_q));
  assign feed     = (state_q == ST_FEED);
  assign emit     = (state_q == ST_EMIT);

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[wr_addr] <= in_i.element_value;
    end
    rd_data_q  <= mem_a[rd_addr];
    rd_inner_q <= 3'(l_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= feed;
    end
  end

  always_comb begin
    state_d = state_q;
    m_d = m_q;
    n_d = n_q;
    k_d = k_q;
    i_d = i_q;
    l_d = l_q;
    w_d = w_q;
    e_d = e_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.mode == MODE_COMPUTE)) begin
          m_d = clamp_dim(rows_a_q);
          n_d = clamp_dim(cols_b_q);
          k_d = clamp_dim(inner_len_q);
          i_d = '0;
          l_d = '0;
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        l_d = l_q + DIM_W'(1);
        if (l_q == k_q - DIM_W'(1)) begin
          w_d = '0;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        w_d = w_q + DIM_W'(1);
        if (int'(w_q) == MAX_DIM - 1) begin
          e_d = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        e_d = e_q + DIM_W'(1);
        if (e_q == n_q - DIM_W'(1)) begin
          if (i_q == m_q - DIM_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + DIM_W'(1);
            l_d = '0;
            state_d = ST_FEED;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_q <= '0;
      n_q <= '0;
      k_q <= '0;
      i_q <= '0;
      l_q <= '0;
      w_q <= '0;
      e_q <= '0;
    end else begin
      state_q <= state_d;
      m_q <= m_d;
      n_q <= n_d;
      k_q <= k_d;
      i_q <= i_d;
      l_q <= l_d;
      w_q <= w_d;
      e_q <= e_d;
    end
  end

  assign ctl.clear  = feed && (l_q == '0);
  assign ctl.shift  = emit;
  assign ctl.b_we   = accept && in_range && (in_i.mode == MODE_LOAD_B);
  assign ctl.b_row  = in_i.row_index;
  assign ctl.b_col  = in_i.col_index;
  assign ctl.b_data = in_i.element_value;

  assign opnd[0].valid = rd_vld_q;
  assign opnd[0].inner = rd_inner_q;
  assign opnd[0].value = rd_data_q;
  assign acc_w[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mm_cell #(
      .MAX_DIM  (MAX_DIM),
      .CELL_IDX (j),
      .ACC_W    (ACC_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .opnd_i     (opnd[j]),
      .opnd_o     (opnd[j+1]),
      .shift_in_i (acc_w[j+1]),
      .acc_o      (acc_w[j])
    );
  end

  assign shifted = acc_w[0] >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q.out_row <= 3'(i_q);
      res_q.out_col <= 3'(e_q);
      res_q.last    <= (i_q == m_q - DIM_W'(1)) && (e_q == n_q - DIM_W'(1));
      if (shifted > SAT_HI) begin
        res_q.out_value <= 16'(SAT_HI);
        res_q.saturated <= 1'b1;
      end else if (shifted < SAT_LO) begin
        res_q.out_value <= 16'(SAT_LO);
        res_q.saturated <= 1'b1;
      end else begin
        res_q.out_value <= 16'(shifted);
        res_q.saturated <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= emit;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result without emit cycle");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (e_q < n_q))
    else $error("emit column out of range");

  a_feed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FEED) |-> (l_q < k_q) && (i_q < m_q))
    else $error("feed index out of range");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (i_q == m_q - DIM_W'(1)) && (e_q == n_q - DIM_W'(1))) |=> !busy_o)
    else $error("run did not end after last item");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for matrix_multiplier_core: element loads and compute
// commands are queued per phase and fed with random gaps, a local
// fixed-point predictor builds the expected result elements, and the monitor
// compares every result strobe against them field by field
// ----------------------------------------------------------------------------
module testbench;
  import mm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM      = 8;
  localparam int LIMIT    = 5000;
  localparam int SETTLE   = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  mm_in_t      in_i = '0;
  logic        result_valid_o;
  mm_out_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [3:0]  cfg_data_i = '0;

  matrix_multiplier_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .in_i(in_i),
    .result_valid_o(result_valid_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  mm_in_t             cmd_q[$];
  mm_out_t            product_q[$];
  logic signed [15:0] a_mem [DIM*DIM];
  logic signed [15:0] b_mem [DIM*DIM];
  logic [3:0]         dim_reg [3] = '{4'd8, 4'd8, 4'd8};
  bit                 a_seen [DIM][DIM];
  bit                 b_seen [DIM][DIM];
  int                 idle_pct = 0;
  int                 errors = 0;
  int                 quiet = 0;

  function automatic int eff_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  task automatic predict_product(mm_in_t it);
    int      m, n, k;
    longint  acc, r;
    mm_out_t res;
    case (it.mode)
      MODE_LOAD_A: a_mem[it.row_index*DIM + it.col_index] = it.element_value;
      MODE_LOAD_B: b_mem[it.row_index*DIM + it.col_index] = it.element_value;
      MODE_COMPUTE: begin
        m = eff_dim(dim_reg[CFG_ROWS_A]);
        n = eff_dim(dim_reg[CFG_COLS_B]);
        k = eff_dim(dim_reg[CFG_INNER_LEN]);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int l = 0; l < k; l++)
              acc += longint'(a_mem[i*DIM + l]) * longint'(b_mem[l*DIM + j]);
            r = acc >>> FRAC_BITS;
            res.saturated = 1'b0;
            if (r > 32767) begin
              r = 32767;
              res.saturated = 1'b1;
            end else if (r < -32768) begin
              r = -32768;
              res.saturated = 1'b1;
            end
            res.out_row = 3'(i);
            res.out_col = 3'(j);
            res.out_value = r[15:0];
            res.last = (i == m-1) && (j == n-1);
            product_q.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    logic hold;
    if (rst_ni) begin
      hold = start_i;
      if (start_i && !busy_o) begin
        predict_product(in_i);
        void'(cmd_q.pop_front());
        hold = 1'b0;
      end
      if (!hold) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start_i <= 1'b1;
          in_i <= cmd_q[0];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mm_out_t want;
    if (rst_ni && result_valid_o) begin
      if (product_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, result_o);
        errors++;
      end else begin
        want = product_q.pop_front();
        if (result_o.out_row !== want.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $realtime, want.out_row,
                   result_o.out_row);
          errors++;
        end
        if (result_o.out_col !== want.out_col) begin
          $display("%0t: out_col expected %0d actual %0d", $realtime, want.out_col,
                   result_o.out_col);
          errors++;
        end
        if (result_o.out_value !== want.out_value) begin
          $display("%0t: out_value expected %0d actual %0d", $realtime, want.out_value,
                   result_o.out_value);
          errors++;
        end
        if (result_o.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $realtime, want.saturated,
                   result_o.saturated);
          errors++;
        end
        if (result_o.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, want.last, result_o.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= CFG_INNER_LEN)
      dim_reg[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_item(logic [1:0] md, int r, int c, logic signed [15:0] v);
    mm_in_t it;
    it.mode = md;
    it.row_index = 3'(r);
    it.col_index = 3'(c);
    it.element_value = v;
    if (md == MODE_LOAD_A) a_seen[r][c] = 1'b1;
    if (md == MODE_LOAD_B) b_seen[r][c] = 1'b1;
    cmd_q.push_back(it);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // queues a load for any entry the product will read that has not been written yet, then the compute
  task automatic push_compute();
    int m, n, k;
    m = eff_dim(dim_reg[CFG_ROWS_A]);
    n = eff_dim(dim_reg[CFG_COLS_B]);
    k = eff_dim(dim_reg[CFG_INNER_LEN]);
    for (int i = 0; i < m; i++)
      for (int l = 0; l < k; l++)
        if (!a_seen[i][l]) push_item(MODE_LOAD_A, i, l, rand_value());
    for (int l = 0; l < k; l++)
      for (int j = 0; j < n; j++)
        if (!b_seen[l][j]) push_item(MODE_LOAD_B, l, j, rand_value());
    push_item(MODE_COMPUTE, $urandom_range(7), $urandom_range(7), 16'($urandom));
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || product_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int          pick;
    int          idle_tbl [4] = '{0, 49, 0, 13};
    logic [3:0]  dims [3];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: 1x1 products at the saturation limits, ignored items
    write_reg(CFG_ROWS_A, 4'd1);
    write_reg(CFG_COLS_B, 4'd1);
    write_reg(CFG_INNER_LEN, 4'd1);
    write_reg(CFG_RESERVED, 4'd5);
    push_item(MODE_LOAD_A, 0, 0, 16'sh8000);
    push_item(MODE_LOAD_B, 0, 0, 16'sh8000);
    push_compute();
    push_item(MODE_LOAD_A, 0, 0, 16'sh7fff);
    push_compute();
    push_item(MODE_LOAD_A, 0, 0, 16'sh0100);
    push_item(MODE_LOAD_B, 0, 0, -16'sh0001);
    push_compute();
    push_item(MODE_RESERVED, 7, 7, 16'sh7fff);
    push_item(MODE_RESERVED, 0, 0, 16'sh0000);
    push_compute();
    push_item(MODE_LOAD_A, 7, 7, 16'sh7fff);
    push_item(MODE_LOAD_B, 7, 7, 16'sh8000);
    push_item(MODE_LOAD_A, 7, 0, 16'sh0000);
    push_item(MODE_LOAD_B, 0, 7, -16'sh0001);
    push_compute();
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: dims = '{4'd8, 4'd8, 4'd8};
        1: dims = '{4'd15, 4'd0, 4'd15};
        2: dims = '{4'd1, 4'd1, 4'd8};
        3: dims = '{4'd0, 4'd15, 4'd0};
        default: dims = '{4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15))};
      endcase
      write_reg(CFG_ROWS_A, dims[0]);
      write_reg(CFG_COLS_B, dims[1]);
      write_reg(CFG_INNER_LEN, dims[2]);
      idle_pct = idle_tbl[p % 4];
      for (int t = 0; t < 30; t++) begin
        pick = $urandom_range(99);
        if (pick < 7)
          push_compute();
        else if (pick < 10)
          push_item(MODE_RESERVED, $urandom_range(7), $urandom_range(7), 16'($urandom));
        else
          push_item(2'($urandom_range(1)), $urandom_range(7), $urandom_range(7),
                    rand_value());
      end
      push_compute();
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== matrix_multiplier_core.f =====
sv/mm_pkg.sv
sv/mm_cell.sv
sv/matrix_multiplier_core.sv
tb/testbench.sv
